// ----- rtl/adaptive_batch_threshold_tuner_top_macros.svh -----
// Assertion macros for the adaptive batch threshold tuner checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ADAPTIVE_BATCH_THRESHOLD_TUNER_TOP_MACROS_SVH
`define ADAPTIVE_BATCH_THRESHOLD_TUNER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/abtt_pkg.sv -----
// Shared types and constants of the adaptive batch threshold tuner.
// No dependencies; every other file but the macro header uses it by scoped names.
`timescale 1ns / 1ps

package abtt_pkg;

    localparam int SIZE_W   = 24;
    localparam int TIME_W   = 16;
    localparam int FACT_W   = 16;
    localparam int DIR_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Q2.14 factors
    localparam int FRAC_BITS = 14;
    localparam int PROD_W    = SIZE_W + FACT_W;
    localparam int SCALED_W  = PROD_W - FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [FACT_W-1:0] FACTOR_ONE = FACT_W'(1) << FRAC_BITS;

    localparam int HIGH_FILL_PCT     = 95;
    localparam int LOW_FILL_PCT      = 50;
    localparam int FULL_PCT          = 100;
    localparam int FILL_W            = SIZE_W + 7;

    localparam logic [SIZE_W-1:0] DEF_MIN_BATCH = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] DEF_MAX_BATCH = SIZE_W'(1) << 20;
    localparam logic [FACT_W-1:0] DEF_SHRINK    = FACT_W'(13926);
    localparam logic [FACT_W-1:0] DEF_GROW      = FACT_W'(18842);
    localparam logic [TIME_W-1:0] DEF_SLOW_US   = TIME_W'(450);
    localparam logic [TIME_W-1:0] DEF_FAST_US   = TIME_W'(200);

    typedef logic signed [DIR_W-1:0] dir_t;
    localparam dir_t DIR_DOWN = 2'sb11;
    localparam dir_t DIR_HOLD = 2'sb00;
    localparam dir_t DIR_UP   = 2'sb01;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_BATCH       = 3'd0,
        REG_MAX_BATCH       = 3'd1,
        REG_SHRINK_FACTOR   = 3'd2,
        REG_GROW_FACTOR     = 3'd3,
        REG_SLOW_FLUSH_US   = 3'd4,
        REG_SLOW_COLLECT_US = 3'd5,
        REG_FAST_FLUSH_US   = 3'd6,
        REG_FAST_COLLECT_US = 3'd7
    } cfg_reg_t;

    // Effective settings after defaults and the max-below-min fix
    typedef struct packed {
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
        logic [FACT_W-1:0] shrink;
        logic [FACT_W-1:0] grow;
        logic [TIME_W-1:0] slow_flush;
        logic [TIME_W-1:0] slow_collect;
        logic [TIME_W-1:0] fast_flush;
        logic [TIME_W-1:0] fast_collect;
    } tune_cfg_t;

endpackage

// ----- rtl/abtt_ifs.sv -----
// Valid/ready channel interfaces: observations in, threshold results out.
// Depends on abtt_pkg.
`timescale 1ns / 1ps

interface abtt_obs_if;
    logic                        valid;
    logic                        ready;
    logic [abtt_pkg::SIZE_W-1:0] observed_size;
    logic [abtt_pkg::TIME_W-1:0] flush_time_us;
    logic [abtt_pkg::TIME_W-1:0] collect_time_us;

    modport source (output valid, observed_size, flush_time_us, collect_time_us,
                    input ready);
    modport sink   (input valid, observed_size, flush_time_us, collect_time_us,
                    output ready);
    modport mon    (input valid, ready, observed_size, flush_time_us, collect_time_us);
endinterface

interface abtt_res_if;
    logic                        valid;
    logic                        ready;
    logic [abtt_pkg::SIZE_W-1:0] new_threshold;
    abtt_pkg::dir_t              direction;

    modport source (output valid, new_threshold, direction, input ready);
    modport sink   (input valid, new_threshold, direction, output ready);
    modport mon    (input valid, ready, new_threshold, direction);
endinterface

// ----- rtl/abtt_cfg.sv -----
// Configuration register file; resolves zero values and out-of-range factors to defaults.
// Depends on abtt_pkg.
`timescale 1ns / 1ps

module abtt_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [abtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abtt_pkg::CFG_DATA_W-1:0] cfg_data,
    output abtt_pkg::tune_cfg_t             cfg
);

    logic [abtt_pkg::SIZE_W-1:0] min_reg;
    logic [abtt_pkg::SIZE_W-1:0] max_reg;
    logic [abtt_pkg::FACT_W-1:0] shrink_reg;
    logic [abtt_pkg::FACT_W-1:0] grow_reg;
    logic [abtt_pkg::TIME_W-1:0] slow_flush_reg;
    logic [abtt_pkg::TIME_W-1:0] slow_collect_reg;
    logic [abtt_pkg::TIME_W-1:0] fast_flush_reg;
    logic [abtt_pkg::TIME_W-1:0] fast_collect_reg;
    logic [abtt_pkg::SIZE_W-1:0] lo;
    logic [abtt_pkg::SIZE_W-1:0] hi_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg          <= '0;
            max_reg          <= '0;
            shrink_reg       <= '0;
            grow_reg         <= '0;
            slow_flush_reg   <= '0;
            slow_collect_reg <= '0;
            fast_flush_reg   <= '0;
            fast_collect_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (abtt_pkg::cfg_reg_t'(cfg_index))
                abtt_pkg::REG_MIN_BATCH:       min_reg <= cfg_data;
                abtt_pkg::REG_MAX_BATCH:       max_reg <= cfg_data;
                abtt_pkg::REG_SHRINK_FACTOR:   shrink_reg <= cfg_data[abtt_pkg::FACT_W-1:0];
                abtt_pkg::REG_GROW_FACTOR:     grow_reg <= cfg_data[abtt_pkg::FACT_W-1:0];
                abtt_pkg::REG_SLOW_FLUSH_US:   slow_flush_reg <= cfg_data[abtt_pkg::TIME_W-1:0];
                abtt_pkg::REG_SLOW_COLLECT_US: slow_collect_reg <= cfg_data[abtt_pkg::TIME_W-1:0];
                abtt_pkg::REG_FAST_FLUSH_US:   fast_flush_reg <= cfg_data[abtt_pkg::TIME_W-1:0];
                abtt_pkg::REG_FAST_COLLECT_US: fast_collect_reg <= cfg_data[abtt_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lo     = (min_reg != '0) ? min_reg : abtt_pkg::DEF_MIN_BATCH;
        hi_raw = (max_reg != '0) ? max_reg : abtt_pkg::DEF_MAX_BATCH;

        cfg.lo = lo;
        // raise max to min when it sits below
        cfg.hi = (hi_raw < lo) ? lo : hi_raw;
        cfg.shrink = (shrink_reg == '0 || shrink_reg >= abtt_pkg::FACTOR_ONE)
                   ? abtt_pkg::DEF_SHRINK : shrink_reg;
        cfg.grow   = (grow_reg <= abtt_pkg::FACTOR_ONE) ? abtt_pkg::DEF_GROW : grow_reg;
        cfg.slow_flush   = (slow_flush_reg != '0) ? slow_flush_reg : abtt_pkg::DEF_SLOW_US;
        cfg.slow_collect = (slow_collect_reg != '0) ? slow_collect_reg
                                                    : abtt_pkg::DEF_SLOW_US;
        cfg.fast_flush   = (fast_flush_reg != '0) ? fast_flush_reg : abtt_pkg::DEF_FAST_US;
        cfg.fast_collect = (fast_collect_reg != '0) ? fast_collect_reg
                                                    : abtt_pkg::DEF_FAST_US;
    end

endmodule

// ----- rtl/abtt_step.sv -----
// One adaptation step: fill and timing tests, one Q2.14 multiply, round and clamp.
// Depends on abtt_pkg.
`timescale 1ns / 1ps

module abtt_step
(
    input  abtt_pkg::tune_cfg_t          cfg,
    input  logic [abtt_pkg::SIZE_W-1:0]  cur_threshold,
    input  logic [abtt_pkg::SIZE_W-1:0]  observed_size,
    input  logic [abtt_pkg::TIME_W-1:0]  flush_time_us,
    input  logic [abtt_pkg::TIME_W-1:0]  collect_time_us,
    output logic [abtt_pkg::SIZE_W-1:0]  new_threshold,
    output abtt_pkg::dir_t               direction
);

    logic [abtt_pkg::SIZE_W-1:0]   start;
    logic [abtt_pkg::SIZE_W-1:0]   base;
    logic [abtt_pkg::FILL_W-1:0]   obs_scaled;
    logic [abtt_pkg::FILL_W-1:0]   full_mark;
    logic [abtt_pkg::FILL_W-1:0]   grow_mark;
    logic                          full;
    logic                          empty;
    logic                          slow;
    logic                          fast;
    logic                          shrink;
    logic                          grow;
    logic [abtt_pkg::FACT_W-1:0]   factor;
    logic [abtt_pkg::PROD_W-1:0]   product;
    logic [abtt_pkg::SCALED_W-1:0] scaled;
    logic [abtt_pkg::SIZE_W-1:0]   clamped;

    always_comb
    begin
        // zero state starts from the minimum; then pull into min..max
        start = (cur_threshold == '0) ? cfg.lo : cur_threshold;
        if (start < cfg.lo)
            base = cfg.lo;
        else if (start > cfg.hi)
            base = cfg.hi;
        else
            base = start;

        obs_scaled = abtt_pkg::FILL_W'(observed_size) * abtt_pkg::FILL_W'(abtt_pkg::FULL_PCT);
        full_mark  = abtt_pkg::FILL_W'(base) * abtt_pkg::FILL_W'(abtt_pkg::HIGH_FILL_PCT);
        grow_mark  = abtt_pkg::FILL_W'(base) * abtt_pkg::FILL_W'(abtt_pkg::LOW_FILL_PCT);
        full  = obs_scaled >= full_mark;
        empty = obs_scaled <= grow_mark;
        slow  = (flush_time_us >= cfg.slow_flush) || (collect_time_us >= cfg.slow_collect);
        fast  = (flush_time_us <= cfg.fast_flush) && (collect_time_us <= cfg.fast_collect);

        shrink = (observed_size != '0) && full && slow;
        grow   = (observed_size != '0) && !shrink && empty && fast;

        // shrink and grow share one multiplier
        factor  = shrink ? cfg.shrink : cfg.grow;
        product = abtt_pkg::PROD_W'(base) * abtt_pkg::PROD_W'(factor)
                + abtt_pkg::ROUND_HALF;
        scaled  = product[abtt_pkg::PROD_W-1:abtt_pkg::FRAC_BITS];

        if (scaled < abtt_pkg::SCALED_W'(cfg.lo))
            clamped = cfg.lo;
        else if (scaled > abtt_pkg::SCALED_W'(cfg.hi))
            clamped = cfg.hi;
        else
            clamped = scaled[abtt_pkg::SIZE_W-1:0];

        new_threshold = (shrink || grow) ? clamped : base;
        if (shrink && clamped < base)
            direction = abtt_pkg::DIR_DOWN;
        else if (grow && clamped > base)
            direction = abtt_pkg::DIR_UP;
        else
            direction = abtt_pkg::DIR_HOLD;
    end

endmodule

// ----- rtl/adaptive_batch_threshold_tuner_top.sv -----
// Channel  | Dir | Payload                                          | Handshake
// ---------+-----+--------------------------------------------------+-----------
// observ.  | in  | observed_size, flush_time_us, collect_time_us    | valid/ready
// result   | out | new_threshold, direction                         | valid/ready
// config   | in  | cfg_index, cfg_data                              | cfg_we only
//
// One observation per cycle sustained while results are taken; each transaction
// is captured in the input register, and the step logic reads it and loads the
// threshold register and the result register when the result slot is free.
// The threshold feedback loops through one 24x16 multiply and clamp.
// Reset clears the threshold (start at minimum), the config and all valid flags.
// A stalled result holds the pipe; observation ready drops only while both
// stages are full and the result is not taken.
`timescale 1ns / 1ps

module adaptive_batch_threshold_tuner_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    abtt_obs_if.sink                        observation,
    abtt_res_if.source                      result,
    input  logic                            cfg_we,
    input  logic [abtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abtt_pkg::CFG_DATA_W-1:0] cfg_data
);

    abtt_pkg::tune_cfg_t         cfg;

    logic                        in_valid_reg;
    logic [abtt_pkg::SIZE_W-1:0] in_size_reg;
    logic [abtt_pkg::TIME_W-1:0] in_flush_reg;
    logic [abtt_pkg::TIME_W-1:0] in_collect_reg;

    logic [abtt_pkg::SIZE_W-1:0] thr_reg;
    logic [abtt_pkg::SIZE_W-1:0] thr_next;
    abtt_pkg::dir_t              dir_next;

    logic                        out_valid_reg;
    logic [abtt_pkg::SIZE_W-1:0] out_thr_reg;
    abtt_pkg::dir_t              out_dir_reg;

    logic                        advance;
    logic                        take_in;

    abtt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abtt_step u_step
    (
        .cfg             (cfg),
        .cur_threshold   (thr_reg),
        .observed_size   (in_size_reg),
        .flush_time_us   (in_flush_reg),
        .collect_time_us (in_collect_reg),
        .new_threshold   (thr_next),
        .direction       (dir_next)
    );

    // result slot frees up when empty or being taken
    assign advance           = !out_valid_reg || result.ready;
    assign observation.ready = !in_valid_reg || advance;
    assign take_in           = observation.valid && observation.ready;

    assign result.valid         = out_valid_reg;
    assign result.new_threshold = out_thr_reg;
    assign result.direction     = out_dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= '0;
        end
        else
        begin
            if (observation.ready)
                in_valid_reg <= observation.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            // commit the threshold only when the step result moves forward
            if (in_valid_reg && advance)
                thr_reg <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_size_reg    <= observation.observed_size;
            in_flush_reg   <= observation.flush_time_us;
            in_collect_reg <= observation.collect_time_us;
        end
        if (in_valid_reg && advance)
        begin
            out_thr_reg <= thr_next;
            out_dir_reg <= dir_next;
        end
    end

endmodule

// ----- rtl/abtt_checker.sv -----
// Port-level checks for the threshold tuner, bound onto the top level.
// Depends on abtt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "adaptive_batch_threshold_tuner_top_macros.svh"

module abtt_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        obs_ready,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  logic [abtt_pkg::SIZE_W-1:0] res_threshold,
    input  abtt_pkg::dir_t              res_direction
);

    `ABTT_ASSERT_NEXT(a_result_held, res_valid && !res_ready,
        res_valid && $stable(res_threshold) && $stable(res_direction), "stalled result changed")
    `ABTT_ASSERT_NOW(a_dir_code, res_valid,
        res_direction == abtt_pkg::DIR_DOWN || res_direction == abtt_pkg::DIR_HOLD
        || res_direction == abtt_pkg::DIR_UP, "bad direction code")
    `ABTT_ASSERT_NOW(a_thr_nonzero, res_valid, res_threshold != '0, "threshold is zero")
    `ABTT_ASSERT_NOW(a_ready_when_empty, !res_valid, obs_ready,
        "input stalled with empty result slot")

endmodule

bind adaptive_batch_threshold_tuner_top abtt_checker u_abtt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .obs_ready     (observation.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_threshold (result.new_threshold),
    .res_direction (result.direction)
);
